// ===== hw/rtl/fdr_pkg.sv =====
`timescale 1ns / 1ps

package fdr_pkg;

    localparam int NumChannels = 4;
    localparam int LevelW      = 8;
    localparam int PctW        = 8;
    localparam int ChanW       = 2;

    localparam logic [LevelW-1:0] LevelOffset = 8'd40;
    localparam int LevelSpan  = 215;
    localparam int PctDivisor = 99;
    localparam logic [PctW-1:0] PctMax = 8'd100;

    localparam int RecipShift = 16;
    localparam int Recip      = (2 ** RecipShift + PctDivisor - 1) / PctDivisor;
    localparam logic [24:0] SpanRecip = 25'(LevelSpan * Recip);

    typedef enum logic [0:0] {
        ACT_SET  = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [ChanW-1:0]     channel;
        logic [PctW-1:0]      percent;
    } t_item;

    typedef logic [LevelW-1:0] t_level;

    // Maps 0..255 percent to a level. The quotient by 99 is taken as a
    // multiplication by a rounded-up reciprocal, exact for all offsets 0..99.
    function automatic t_level pct_to_level(logic [PctW-1:0] pct);
        logic [6:0]  idx;
        logic [24:0] prod;
        t_level      res;
        if (pct == '0) begin
            res = '0;
        end else begin
            if (pct > PctMax) begin
                idx = 7'(PctMax - 8'd1);
            end else begin
                idx = 7'(pct - 8'd1);
            end
            prod = 25'(idx) * SpanRecip;
            res  = LevelOffset + LevelW'(prod >> RecipShift);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/fdr_in_stage.sv =====
`timescale 1ns / 1ps

module fdr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fdr_pkg::t_item i_item,
    input  logic          i_adv,
    output logic          o_stall,
    output logic          o_valid,
    output fdr_pkg::t_item o_item
);
    import fdr_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/fdr_core_stage.sv =====
`timescale 1ns / 1ps

module fdr_core_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic           i_out_stall,
    input  fdr_pkg::t_item i_item,
    output logic           o_valid,
    output fdr_pkg::t_level o_level [fdr_pkg::NumChannels],
    output logic           o_armed
);
    import fdr_pkg::*;

    t_level r_cur [NumChannels];
    t_level r_tgt [NumChannels];
    t_level n_cur [NumChannels];
    t_level n_tgt [NumChannels];
    logic   r_armed;
    logic   n_armed;
    logic   r_valid;
    logic   moved;
    t_level new_level;

    assign new_level = pct_to_level(i_item.percent);

    always_comb begin
        moved   = 1'b0;
        n_armed = r_armed;
        for (int i = 0; i < NumChannels; i++) begin
            n_cur[i] = r_cur[i];
            n_tgt[i] = r_tgt[i];
        end
        if (i_item.action == ACT_SET) begin
            n_tgt[i_item.channel] = new_level;
            n_armed = 1'b1;
        end else if (r_armed) begin
            for (int i = 0; i < NumChannels; i++) begin
                if (r_cur[i] < r_tgt[i]) begin
                    n_cur[i] = r_cur[i] + 8'd1;
                    moved    = 1'b1;
                end else if (r_cur[i] > r_tgt[i]) begin
                    n_cur[i] = r_cur[i] - 8'd1;
                    moved    = 1'b1;
                end
            end
            n_armed = moved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_armed <= 1'b0;
            for (int i = 0; i < NumChannels; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            if (i_fire) begin
                r_valid <= 1'b1;
                r_armed <= n_armed;
                for (int i = 0; i < NumChannels; i++) begin
                    r_cur[i] <= n_cur[i];
                    r_tgt[i] <= n_tgt[i];
                end
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_armed = r_armed;
    assign o_level = r_cur;

endmodule

// ===== hw/rtl/four_channel_dimmer_ramp_core.sv =====
`timescale 1ns / 1ps

// Four-channel dimmer slew limiter. A set transaction maps a percentage
// to a level (0 for 0, 40 to 255 for 1 to 100, above 100 held at 100) and
// makes it the target of one channel, arming the ramp; a tick transaction
// steps every channel one level toward its target while the ramp is armed.
// Each input transaction yields exactly one result transaction carrying the
// four current levels and the armed flag as they stand after it. The block
// takes one transaction per clock cycle unless the result side stalls. It
// has two registers: one input register, then the channel state registers,
// which also serve as the result register. A stall on the result side holds
// the input side only once both registers are full.
module four_channel_dimmer_ramp_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [0:0] i_action,
    input  logic [1:0] i_channel,
    input  logic [7:0] i_percent,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_level_zero,
    output logic [7:0] o_level_one,
    output logic [7:0] o_level_two,
    output logic [7:0] o_level_three,
    output logic       o_ramping
);
    import fdr_pkg::*;

    t_item  in_item;
    t_item  a_item;
    logic   a_valid;
    logic   fire;
    t_level levels [NumChannels];

    assign in_item.action  = t_action'(i_action);
    assign in_item.channel = i_channel;
    assign in_item.percent = i_percent;

    assign fire = a_valid && (!o_out_valid || !i_out_stall);

    fdr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_adv   (fire),
        .o_stall (o_in_stall),
        .o_valid (a_valid),
        .o_item  (a_item)
    );

    fdr_core_stage u_core_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_out_stall (i_out_stall),
        .i_item      (a_item),
        .o_valid     (o_out_valid),
        .o_level     (levels),
        .o_armed     (o_ramping)
    );

    assign o_level_zero  = levels[0];
    assign o_level_one   = levels[1];
    assign o_level_two   = levels[2];
    assign o_level_three = levels[3];

    a_set_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && a_item.action == ACT_SET |=> o_ramping)
        else $error("set transaction did not arm the ramp");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ramping && !(fire && a_item.action == ACT_SET) |=>
            $stable(o_level_zero) && $stable(o_level_one)
            && $stable(o_level_two) && $stable(o_level_three))
        else $error("level changed while the ramp was disarmed");

    a_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> o_level_zero == $past(o_level_zero)
            || o_level_zero == $past(o_level_zero) + 8'd1
            || o_level_zero == $past(o_level_zero) - 8'd1)
        else $error("channel zero moved by more than one level");

    a_no_move_without_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(o_level_three) && $stable(o_ramping))
        else $error("state changed without an advancing transaction");

endmodule
